@@ src/ifp_pkg.sv @@
// Shared types and constants for the IMU frame packer.
`timescale 1ns / 1ps

package ifp_pkg;

    localparam int SLOT_W     = 6;
    localparam int MASK_W     = 36;
    localparam int DATA_BYTES = 19;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAULT_MASK    = 2'd2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef struct packed {
        logic                             first;
        logic                             last;
        logic [7:0]                       hdr_first;
        logic [7:0]                       hdr_second;
        logic [15:0]                      count;
        logic [DATA_BYTES-1:0][7:0]       data;
    } t_desc;

endpackage

@@ src/ifp_front.sv @@
// Front end: configuration registers, slot tracking and slot byte assembly.
`timescale 1ns / 1ps

module ifp_front
    import ifp_pkg::*;
#(
    parameter int SENSOR_SLOTS = 36
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [MASK_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_present,
    input  logic signed [19:0]   i_accel_x,
    input  logic signed [19:0]   i_accel_y,
    input  logic signed [19:0]   i_accel_z,
    input  logic signed [19:0]   i_gyro_x,
    input  logic signed [19:0]   i_gyro_y,
    input  logic signed [19:0]   i_gyro_z,
    input  logic signed [15:0]   i_temperature,
    input  logic [15:0]          i_sample_time,
    output logic                 o_push,
    output t_desc                o_desc,
    input  logic                 i_q_ready
);

    logic [7:0]        r_hdr_first;
    logic [7:0]        r_hdr_second;
    logic [MASK_W-1:0] r_fault_mask;
    logic [SLOT_W-1:0] r_slot;
    logic [15:0]       r_count;

    logic w_fault;
    logic w_use;
    logic w_last;
    logic w_first;
    logic w_acc;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = i_q_ready;
    assign w_acc       = i_in_valid && i_q_ready;
    assign o_push      = w_acc;

    assign w_fault = (r_slot < SLOT_W'(MASK_W)) ? r_fault_mask[r_slot] : 1'b0;
    assign w_use   = i_present && !w_fault;
    assign w_first = (r_slot == '0);
    assign w_last  = (r_slot == SLOT_W'(SENSOR_SLOTS - 1));

    always_comb begin
        o_desc.first      = w_first;
        o_desc.last       = w_last;
        o_desc.hdr_first  = r_hdr_first;
        o_desc.hdr_second = r_hdr_second;
        o_desc.count      = r_count;
        o_desc.data       = '0;
        if (w_use) begin
            o_desc.data[0]  = i_accel_x[19:12];
            o_desc.data[1]  = i_accel_x[11:4];
            o_desc.data[2]  = i_accel_y[19:12];
            o_desc.data[3]  = i_accel_y[11:4];
            o_desc.data[4]  = i_accel_z[19:12];
            o_desc.data[5]  = i_accel_z[11:4];
            o_desc.data[6]  = i_gyro_x[19:12];
            o_desc.data[7]  = i_gyro_x[11:4];
            o_desc.data[8]  = i_gyro_y[19:12];
            o_desc.data[9]  = i_gyro_y[11:4];
            o_desc.data[10] = i_gyro_z[19:12];
            o_desc.data[11] = i_gyro_z[11:4];
            o_desc.data[12] = i_temperature[15:8];
            o_desc.data[13] = i_temperature[7:0];
            o_desc.data[14] = i_sample_time[15:8];
            o_desc.data[15] = i_sample_time[7:0];
            o_desc.data[16] = {i_accel_x[3:0], i_gyro_x[3:0]};
            o_desc.data[17] = {i_accel_y[3:0], i_gyro_y[3:0]};
            o_desc.data[18] = {i_accel_z[3:0], i_gyro_z[3:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_first  <= '0;
            r_hdr_second <= '0;
            r_fault_mask <= '0;
            r_slot       <= '0;
            r_count      <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_HEADER_FIRST:  r_hdr_first  <= i_cfg_data[7:0];
                    CFG_HEADER_SECOND: r_hdr_second <= i_cfg_data[7:0];
                    CFG_FAULT_MASK:    r_fault_mask <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_acc) begin
                if (w_last) begin
                    r_slot  <= '0;
                    r_count <= r_count + 16'd1;
                end else begin
                    r_slot  <= r_slot + SLOT_W'(1);
                end
            end
        end
    end

    a_slot_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_last) |=> (r_slot == '0))
        else $error("slot index did not wrap after last slot");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_W'(SENSOR_SLOTS - 1))
        else $error("slot index out of range");

endmodule

@@ src/ifp_queue.sv @@
// Two-entry slot descriptor queue between front and back end.
`timescale 1ns / 1ps

module ifp_queue
    import ifp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    output logic  o_ready,
    input  logic  i_pop,
    output logic  o_valid,
    output t_desc o_desc
);

    t_desc      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_wr;
    logic       w_rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_desc  = r_mem[r_rp];
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("queue occupancy overflow");

endmodule

@@ src/ifp_back.sv @@
// Back end: byte sequencer with running CRC and registered output stage.
`timescale 1ns / 1ps

module ifp_back
    import ifp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_desc      i_q_desc,
    output logic       o_q_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_frame_end
);

    typedef enum logic [1:0] {S_IDLE, S_HDR, S_DATA, S_CRC} t_state;

    t_state      r_state;
    t_desc       r_desc;
    logic [4:0]  r_idx;
    logic [15:0] r_crc;
    logic        r_ov;
    logic [7:0]  r_byte;
    logic        r_end;

    logic        w_emit;
    logic [7:0]  w_byte;

    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;
    assign w_emit      = (r_state != S_IDLE) && (!r_ov || i_out_ready);
    assign o_out_valid = r_ov;
    assign o_out_byte  = r_byte;
    assign o_frame_end = r_end;

    always_comb begin
        w_byte = 8'h00;
        unique case (r_state)
            S_HDR: begin
                unique case (r_idx[1:0])
                    2'd0: w_byte = r_desc.hdr_first;
                    2'd1: w_byte = r_desc.hdr_second;
                    2'd2: w_byte = r_desc.count[7:0];
                    2'd3: w_byte = r_desc.count[15:8];
                endcase
            end
            S_DATA:  w_byte = r_desc.data[r_idx];
            S_CRC:   w_byte = r_idx[0] ? r_crc[15:8] : r_crc[7:0];
            default: w_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_crc   <= CRC_INIT;
            r_ov    <= 1'b0;
            r_end   <= 1'b0;
        end else begin
            if (w_emit) begin
                r_ov   <= 1'b1;
                r_byte <= w_byte;
                r_end  <= (r_state == S_CRC) && r_idx[0];
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_desc  <= i_q_desc;
                        r_idx   <= '0;
                        r_state <= i_q_desc.first ? S_HDR : S_DATA;
                        if (i_q_desc.first) begin
                            r_crc <= CRC_INIT;
                        end
                    end
                end
                S_HDR: begin
                    if (w_emit) begin
                        if (r_idx[1]) begin
                            r_crc <= crc_add(r_crc, w_byte);
                        end
                        if (r_idx == 5'd3) begin
                            r_idx   <= '0;
                            r_state <= S_DATA;
                        end else begin
                            r_idx <= r_idx + 5'd1;
                        end
                    end
                end
                S_DATA: begin
                    if (w_emit) begin
                        r_crc <= crc_add(r_crc, w_byte);
                        if (r_idx == 5'(DATA_BYTES - 1)) begin
                            r_idx   <= '0;
                            r_state <= r_desc.last ? S_CRC : S_IDLE;
                        end else begin
                            r_idx <= r_idx + 5'd1;
                        end
                    end
                end
                S_CRC: begin
                    if (w_emit) begin
                        if (r_idx[0]) begin
                            r_idx   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + 5'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_end_on_crc_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && r_state == S_CRC && r_idx[0]) |=> (r_ov && r_end))
        else $error("frame end missing on high CRC byte");

    a_no_end_elsewhere: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && r_state != S_CRC) |=> !r_end)
        else $error("frame end outside CRC phase");

    a_data_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DATA) |-> (r_idx <= 5'(DATA_BYTES - 1)))
        else $error("data byte index out of range");

endmodule

@@ src/imu_frame_packer_crc16.sv @@
// Top level of the IMU telemetry frame packer with CRC16-CCITT trailer.
//
// Usage: write header_first (index 0), header_second (index 1) and the
// 36-bit fault_mask (index 2) on the cfg channel while the block is idle;
// o_cfg_ready is always high. Present one sensor slot per transaction on
// the input channel, slots in order 0 .. SENSOR_SLOTS-1. Each slot yields
// 19 sample bytes on the output channel; slot 0 is preceded by the two
// header bytes and the frame counter (low byte first), and the last slot
// is followed by the CRC (low byte first) with o_frame_end on its high byte.
// The first byte of a slot passes the queue, the back end's descriptor load
// and the output register once the back end is free. Throughput: one byte per
// cycle while the receiver accepts, plus a load step in the idle state before
// each slot, set by the serial byte output. A two-entry queue lets input
// transactions be taken while bytes of earlier slots are still being sent.
// When the receiver stalls the output register holds its byte; the queue
// fills and o_in_ready drops. Reset clears the configuration registers, the
// slot index and the frame counter and empties the queue.
`timescale 1ns / 1ps

module imu_frame_packer_crc16
    import ifp_pkg::*;
#(
    parameter int SENSOR_SLOTS = 36
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [MASK_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_present,
    input  logic signed [19:0]   i_accel_x,
    input  logic signed [19:0]   i_accel_y,
    input  logic signed [19:0]   i_accel_z,
    input  logic signed [19:0]   i_gyro_x,
    input  logic signed [19:0]   i_gyro_y,
    input  logic signed [19:0]   i_gyro_z,
    input  logic signed [15:0]   i_temperature,
    input  logic [15:0]          i_sample_time,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_out_byte,
    output logic                 o_frame_end
);

    logic  w_push;
    logic  w_q_ready;
    logic  w_q_valid;
    logic  w_pop;
    t_desc w_front_desc;
    t_desc w_back_desc;

    ifp_front #(
        .SENSOR_SLOTS(SENSOR_SLOTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_present    (i_present),
        .i_accel_x    (i_accel_x),
        .i_accel_y    (i_accel_y),
        .i_accel_z    (i_accel_z),
        .i_gyro_x     (i_gyro_x),
        .i_gyro_y     (i_gyro_y),
        .i_gyro_z     (i_gyro_z),
        .i_temperature(i_temperature),
        .i_sample_time(i_sample_time),
        .o_push       (w_push),
        .o_desc       (w_front_desc),
        .i_q_ready    (w_q_ready)
    );

    ifp_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_desc (w_front_desc),
        .o_ready(w_q_ready),
        .i_pop  (w_pop),
        .o_valid(w_q_valid),
        .o_desc (w_back_desc)
    );

    ifp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_desc   (w_back_desc),
        .o_q_pop    (w_pop),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_byte (o_out_byte),
        .o_frame_end(o_frame_end)
    );

endmodule
